### sv/event_trigger_threshold_check_core_defines.svh
// Assertion macros for the event trigger threshold check core.
// Used by files that include this header; expects i_clk and i_rst_n in scope.
`ifndef EVENT_TRIGGER_THRESHOLD_CHECK_CORE_DEFINES_SVH
`define EVENT_TRIGGER_THRESHOLD_CHECK_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define ETTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define ETTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ettc_pkg.sv
// Shared constants for the event trigger threshold check core.
// No dependencies.
package ettc_pkg;

    localparam int MAX_ELEMENTS_DEF = 16;

    localparam int SUM_W  = 40;      // Q16.24 square sums
    localparam int ROOT_W = 21;      // unsaturated root width
    localparam int NORM_W = 18;      // reported norm width
    localparam int SIG_W  = 16;
    localparam int MAG_W  = 17;      // magnitude of a difference
    localparam int MUL_W  = 21;      // shared multiplier operand width
    localparam int IDX_W  = 5;       // root step index
    localparam int ROOT_STEPS = 21;  // one step per result bit

    localparam logic [1:0] MODE_ABS = 2'd0;
    localparam logic [1:0] MODE_REL = 2'd1;
    localparam logic [1:0] MODE_MIX = 2'd2;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_SIGMA   = 2'd1;
    localparam logic [1:0] REG_EPSILON = 2'd2;

    localparam logic [1:0]        MODE_RST    = MODE_MIX;
    localparam logic [SIG_W-1:0]  SIGMA_RST   = 16'd6554;
    localparam logic [NORM_W-1:0] EPSILON_RST = 18'd41;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

endpackage

### sv/event_trigger_threshold_check_core.sv
// Event trigger threshold check: saturating square sums, shared root unit, trigger test.
// Depends on ettc_pkg and event_trigger_threshold_check_core_defines.svh.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------------
//  input   | start / busy              | i_cur_value, i_held_value, i_last_element
//  result  | o_done (one-cycle strobe) | o_fire, o_error_norm, o_state_mag
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An accumulated element runs S_SQ_E, S_SQ_S, S_ACC on the shared multiplier and adder.
// A last element adds two roots of 21 steps each, the sigma product and the test.
// Elements past MAX_ELEMENTS leave busy low (last skips to the roots, product and test).
// Synchronous active-low reset restores control and config state and clears the sums.
// The result strobe lasts one cycle; the receiver cannot stall it.
`include "event_trigger_threshold_check_core_defines.svh"

module event_trigger_threshold_check_core #(
    parameter int MAX_ELEMENTS = ettc_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [15:0]            i_cur_value,
    input  logic signed [15:0]            i_held_value,
    input  logic                          i_last_element,
    output logic                          o_done,
    output logic                          o_fire,
    output logic [ettc_pkg::NORM_W-1:0]   o_error_norm,
    output logic [ettc_pkg::NORM_W-1:0]   o_state_mag,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [ettc_pkg::NORM_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SW = ettc_pkg::SUM_W;
    localparam int RW = ettc_pkg::ROOT_W;
    localparam int MW = ettc_pkg::MUL_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQ_E   = 3'd1;
    localparam logic [2:0] S_SQ_S   = 3'd2;
    localparam logic [2:0] S_ACC    = 3'd3;
    localparam logic [2:0] S_ROOT_E = 3'd4;
    localparam logic [2:0] S_ROOT_S = 3'd5;
    localparam logic [2:0] S_MUL    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [ettc_pkg::IDX_W-1:0] IDX_TOP = ettc_pkg::IDX_W'(ettc_pkg::ROOT_STEPS - 1);

    // control and configuration
    logic [2:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [SW-1:0]                 r_err_sum, n_err_sum;
    logic [SW-1:0]                 r_st_sum, n_st_sum;
    logic                          r_done, n_done;
    logic [1:0]                    r_mode;
    logic [ettc_pkg::SIG_W-1:0]    r_sigma;
    logic [ettc_pkg::NORM_W-1:0]   r_epsilon;

    // payload
    logic signed [15:0]            r_cur, n_cur;
    logic signed [15:0]            r_held, n_held;
    logic                          r_last, n_last;
    logic [2*MW-1:0]               r_prod, n_prod;
    logic [SW-1:0]                 r_rem, n_rem;
    logic [RW-1:0]                 r_res, n_res;
    logic [ettc_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [RW-1:0]                 r_err_root, n_err_root;
    logic [RW-1:0]                 r_st_root, n_st_root;
    logic                          r_fire, n_fire;
    logic [ettc_pkg::NORM_W-1:0]   r_err_norm, n_err_norm;
    logic [ettc_pkg::NORM_W-1:0]   r_st_norm, n_st_norm;

    logic signed [16:0]            diff;
    logic [ettc_pkg::MAG_W-1:0]    mag_err, mag_st;
    logic [MW-1:0]                 mul_a, mul_b;
    logic [2*MW-1:0]               mul_p;
    logic [SW:0]                   add_sum;
    logic [SW-1:0]                 add_a;
    logic [SW-1:0]                 add_sat;
    logic [RW-1:0]                 root_bit;
    logic [RW:0]                   root_trial;
    logic                          root_take;
    logic [SW-1:0]                 step_rem;
    logic [RW-1:0]                 step_res;
    logic [37:0]                   lhs, rhs_mix;
    logic                          fire_cmp;
    logic                          accept;
    logic                          room;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign room        = (r_count < CNT_W'(MAX_ELEMENTS));

    assign o_done       = r_done;
    assign o_fire       = r_fire;
    assign o_error_norm = r_err_norm;
    assign o_state_mag  = r_st_norm;

    // magnitudes of the latched word
    assign diff    = 17'(r_held) - 17'(r_cur);
    assign mag_err = diff[16] ? 17'(-diff) : 17'(diff);
    assign mag_st  = r_cur[15] ? 17'(-17'(r_cur)) : 17'(17'(r_cur));

    // shared multiplier
    always_comb begin
        case (r_state)
            S_SQ_E: begin
                mul_a = MW'(mag_err);
                mul_b = MW'(mag_err);
            end
            S_SQ_S: begin
                mul_a = MW'(mag_st);
                mul_b = MW'(mag_st);
            end
            default: begin
                mul_a = MW'(r_sigma);
                mul_b = MW'(r_st_root);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // shared saturating adder
    assign add_a   = (r_state == S_SQ_S) ? r_err_sum : r_st_sum;
    assign add_sum = {1'b0, add_a} + {1'b0, r_prod[SW-1:0]};
    assign add_sat = add_sum[SW] ? ettc_pkg::SUM_MAX : add_sum[SW-1:0];

    // shared root step: one result bit per cycle
    always_comb begin
        root_bit   = '0;
        root_bit   = root_bit | (RW'(1) << r_idx);
        root_trial = {1'b0, r_res} + {1'b0, root_bit};
    end
    // compare the remainder against 2 * res * 2^idx + 4^idx
    logic [SW+1:0] trial_wide;
    logic [SW+1:0] bit_wide;
    always_comb begin
        bit_wide   = (SW+2)'(1) << {r_idx, 1'b0};
        trial_wide = (((SW+2)'(r_res) << r_idx) << 1) + bit_wide;
        root_take  = ({2'b00, r_rem} >= trial_wide);
        step_rem   = root_take ? SW'({2'b00, r_rem} - trial_wide) : r_rem;
        step_res   = root_take ? root_trial[RW-1:0] : r_res;
    end

    // trigger test
    assign lhs     = 38'({r_err_root, 16'd0});
    assign rhs_mix = 38'(r_prod) + 38'({r_epsilon, 16'd0});
    always_comb begin
        case (r_mode)
            ettc_pkg::MODE_ABS: fire_cmp = (r_err_root > RW'(r_epsilon));
            ettc_pkg::MODE_REL: fire_cmp = (lhs > 38'(r_prod));
            default:            fire_cmp = (lhs > rhs_mix);
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_err_sum  = r_err_sum;
        n_st_sum   = r_st_sum;
        n_done     = 1'b0;
        n_cur      = r_cur;
        n_held     = r_held;
        n_last     = r_last;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_res      = r_res;
        n_idx      = r_idx;
        n_err_root = r_err_root;
        n_st_root  = r_st_root;
        n_fire     = r_fire;
        n_err_norm = r_err_norm;
        n_st_norm  = r_st_norm;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cur  = i_cur_value;
                    n_held = i_held_value;
                    n_last = i_last_element;
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                        n_state = S_SQ_E;
                    end else if (i_last_element) begin
                        // vector overflowed: skip accumulation, still report
                        n_rem   = r_err_sum;
                        n_res   = '0;
                        n_idx   = IDX_TOP;
                        n_state = S_ROOT_E;
                    end
                end
            end
            S_SQ_E: begin
                n_prod  = mul_p;
                n_state = S_SQ_S;
            end
            S_SQ_S: begin
                n_err_sum = add_sat;
                n_prod    = mul_p;
                n_state   = S_ACC;
            end
            S_ACC: begin
                n_st_sum = add_sat;
                if (r_last) begin
                    n_rem   = r_err_sum;
                    n_res   = '0;
                    n_idx   = IDX_TOP;
                    n_state = S_ROOT_E;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROOT_E: begin
                n_rem = step_rem;
                n_res = step_res;
                n_idx = r_idx - ettc_pkg::IDX_W'(1);
                if (r_idx == '0) begin
                    n_err_root = step_res;
                    n_rem      = r_st_sum;
                    n_res      = '0;
                    n_idx      = IDX_TOP;
                    n_state    = S_ROOT_S;
                end
            end
            S_ROOT_S: begin
                n_rem = step_rem;
                n_res = step_res;
                n_idx = r_idx - ettc_pkg::IDX_W'(1);
                if (r_idx == '0) begin
                    n_st_root = step_res;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_fire     = fire_cmp;
                n_err_norm = (r_err_root > RW'(ettc_pkg::NORM_MAX)) ?
                             ettc_pkg::NORM_MAX : r_err_root[ettc_pkg::NORM_W-1:0];
                n_st_norm  = (r_st_root > RW'(ettc_pkg::NORM_MAX)) ?
                             ettc_pkg::NORM_MAX : r_st_root[ettc_pkg::NORM_W-1:0];
                n_done     = 1'b1;
                n_err_sum  = '0;
                n_st_sum   = '0;
                n_count    = '0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_err_sum <= '0;
            r_st_sum  <= '0;
            r_done    <= 1'b0;
            r_mode    <= ettc_pkg::MODE_RST;
            r_sigma   <= ettc_pkg::SIGMA_RST;
            r_epsilon <= ettc_pkg::EPSILON_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_err_sum <= n_err_sum;
            r_st_sum  <= n_st_sum;
            r_done    <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ettc_pkg::REG_MODE:    r_mode    <= i_cfg_data[1:0];
                    ettc_pkg::REG_SIGMA:   r_sigma   <= i_cfg_data[ettc_pkg::SIG_W-1:0];
                    ettc_pkg::REG_EPSILON: r_epsilon <= i_cfg_data;
                    default: ;  // drop writes past the register list
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_held     <= n_held;
        r_last     <= n_last;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_res      <= n_res;
        r_idx      <= n_idx;
        r_err_root <= n_err_root;
        r_st_root  <= n_st_root;
        r_fire     <= n_fire;
        r_err_norm <= n_err_norm;
        r_st_norm  <= n_st_norm;
    end

    `ETTC_ASSERT_NEXT(a_done_follows, r_state == S_DONE, o_done && !busy, "result strobe missing after test")
    `ETTC_ASSERT_NOW(a_done_idle, o_done, r_state == S_IDLE && r_count == '0, "strobe while block not cleared")
    `ETTC_ASSERT_NEXT(a_root_hand, r_state == S_ROOT_E && r_idx == '0, r_state == S_ROOT_S && r_idx == IDX_TOP, "root unit not handed to state sum")
    `ETTC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ELEMENTS), "element count past limit")

endmodule
